/* rtl/pidtr_pkg.sv */
`default_nettype none
package pidtr_pkg;

	localparam int DataW  = 32;
	localparam int GainW  = 31;
	localparam int WghtW  = 16;
	localparam int SumW   = 48;
	localparam int DiffW  = 33;
	localparam int MulAW  = 35;
	localparam int MulBW  = 32;
	localparam int ProdW  = MulAW + MulBW;
	localparam int SplitW = 24;
	localparam int LoW    = SplitW + GainW;
	localparam int FullW  = 81;
	localparam int AccW   = 66;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_PROP     = 3'd0,
		REG_GAIN_INT_DT   = 3'd1,
		REG_GAIN_DER      = 3'd2,
		REG_DEAD_ZONE     = 3'd3,
		REG_BASE_DRIVE    = 3'd4,
		REG_MEAS_SMOOTH   = 3'd5,
		REG_DIFF_SMOOTH   = 3'd6,
		REG_DRIVE_CEILING = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MUL_MEAS = 3'd0,
		MUL_DIFF = 3'd1,
		MUL_P    = 3'd2,
		MUL_ILO  = 3'd3,
		MUL_IHI  = 3'd4,
		MUL_D    = 3'd5
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     load_in;
		logic     seed;
		logic     meas_fin;
		logic     err_en;
		logic     sum_en;
		logic     dfin;
		logic     term_en;
		logic     term_lo;
		logic     lo_en;
		logic     acc_en;
		logic     clamp_en;
	} dp_cmd_t;

	typedef struct packed {
		logic first;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/pidtr_dp.sv */
`default_nettype none
module pidtr_dp
	import pidtr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output      dp_stat_t              stat,
	input  wire logic signed [DataW-1:0] target,
	input  wire logic signed [DataW-1:0] sample,
	input  wire logic                  cfg_we,
	input  wire logic [CfgIdxW-1:0]    cfg_index,
	input  wire logic [DataW-1:0]      cfg_data,
	output      logic [DataW-1:0]      drive
);

	logic [GainW-1:0]        gain_prop_q, gain_int_q, gain_der_q, dead_zone_q;
	logic signed [DataW-1:0] base_q, ceil_q;
	logic [WghtW-1:0]        meas_w_q, diff_w_q;

	logic signed [DataW-1:0] target_q, sample_q, smooth_meas_q, err_q, last_err_q;
	logic                    first_q;
	logic signed [SumW-1:0]  err_sum_q, sum_new_q;
	logic signed [DiffW-1:0] raw_q, smooth_diff_q;
	logic signed [ProdW-1:0] prod_q;
	logic [LoW-1:0]          lo_q;
	logic signed [AccW-1:0]  term_q, acc_q;
	logic [DataW-1:0]        out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q <= '0;
			gain_int_q  <= '0;
			gain_der_q  <= '0;
			dead_zone_q <= '0;
			base_q      <= '0;
			meas_w_q    <= '0;
			diff_w_q    <= '0;
			ceil_q      <= 32'sh7fffffff;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_PROP:     gain_prop_q <= cfg_data[GainW-1:0];
				REG_GAIN_INT_DT:   gain_int_q  <= cfg_data[GainW-1:0];
				REG_GAIN_DER:      gain_der_q  <= cfg_data[GainW-1:0];
				REG_DEAD_ZONE:     dead_zone_q <= cfg_data[GainW-1:0];
				REG_BASE_DRIVE:    base_q      <= cfg_data;
				REG_MEAS_SMOOTH:   meas_w_q    <= cfg_data[WghtW-1:0];
				REG_DIFF_SMOOTH:   diff_w_q    <= cfg_data[WghtW-1:0];
				REG_DRIVE_CEILING: ceil_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared multiplier, filters are computed as new + w*(old-new)
	logic signed [DiffW-1:0]   mdiff;
	logic signed [DiffW:0]     ddiff;
	logic signed [MulAW-1:0]   mul_a;
	logic signed [MulBW-1:0]   mul_b;
	logic signed [ProdW-1:0]   prod_d;

	assign mdiff = DiffW'(smooth_meas_q) - DiffW'(sample_q);
	assign ddiff = (DiffW+1)'(smooth_diff_q) - (DiffW+1)'(raw_q);

	always_comb begin
		mul_a = MulAW'(err_q);
		mul_b = {1'b0, gain_prop_q};
		case (cmd.mul_sel)
			MUL_MEAS: begin
				mul_a = MulAW'(mdiff);
				mul_b = {16'd0, meas_w_q};
			end
			MUL_DIFF: begin
				mul_a = MulAW'(ddiff);
				mul_b = {16'd0, diff_w_q};
			end
			MUL_P: begin
				mul_a = MulAW'(err_q);
				mul_b = {1'b0, gain_prop_q};
			end
			MUL_ILO: begin
				mul_a = {11'd0, sum_new_q[SplitW-1:0]};
				mul_b = {1'b0, gain_int_q};
			end
			MUL_IHI: begin
				mul_a = MulAW'($signed(sum_new_q[SumW-1:SplitW]));
				mul_b = {1'b0, gain_int_q};
			end
			MUL_D: begin
				mul_a = MulAW'(smooth_diff_q);
				mul_b = {1'b0, gain_der_q};
			end
			default: ;
		endcase
	end

	assign prod_d = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	// round half up then floor shift
	logic signed [ProdW-1:0] prod_rnd;
	assign prod_rnd = (prod_q + ProdW'(32'sd32768)) >>> 16;

	// error with saturation and deadband
	logic signed [DataW:0]   e_wide;
	logic signed [DataW-1:0] e_sat, e_db;
	logic signed [DataW:0]   e_ext, e_mag;

	always_comb begin
		e_wide = (DataW+1)'(target_q) - (DataW+1)'(smooth_meas_q);
		if (e_wide > 33'sd2147483647)
			e_sat = 32'sh7fffffff;
		else if (e_wide < -33'sd2147483648)
			e_sat = 32'sh80000000;
		else
			e_sat = e_wide[DataW-1:0];
		e_ext = (DataW+1)'(e_sat);
		e_mag = e_sat[DataW-1] ? -e_ext : e_ext;
		e_db  = (e_mag < $signed({2'b00, dead_zone_q})) ? '0 : e_sat;
	end

	logic signed [SumW:0]    s_wide;
	logic signed [SumW-1:0]  s_sat;

	always_comb begin
		s_wide = (SumW+1)'(err_sum_q) + (SumW+1)'(err_q);
		if (s_wide > 49'sh0_7fff_ffff_ffff)
			s_sat = 48'sh7fff_ffff_ffff;
		else if (s_wide < -49'sh0_8000_0000_0000)
			s_sat = 48'sh8000_0000_0000;
		else
			s_sat = s_wide[SumW-1:0];
	end

	// gain term, the integral hi half joins its low partial product
	logic signed [FullW-1:0] full, full_r;
	logic signed [FullW-1:0] lo_ext;

	assign lo_ext = $signed({26'd0, lo_q});
	assign full   = cmd.term_lo ? ((FullW'(prod_q) <<< SplitW) + lo_ext) : FullW'(prod_q);
	assign full_r = (full + FullW'(32'sd32768)) >>> 16;

	// output clamps, lower one last
	logic signed [AccW-1:0]  ceil_ext, base_ext, v_hi;
	logic                    over;
	logic [DataW-1:0]        drive_d;

	always_comb begin
		ceil_ext = AccW'(ceil_q);
		base_ext = AccW'(base_q);
		over     = acc_q > ceil_ext;
		v_hi     = over ? ceil_ext : acc_q;
		drive_d  = (v_hi < base_ext) ? base_q : v_hi[DataW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q       <= 1'b1;
			smooth_meas_q <= '0;
			err_sum_q     <= '0;
			last_err_q    <= '0;
			smooth_diff_q <= '0;
		end else begin
			if (cmd.seed) begin
				smooth_meas_q <= sample_q;
				first_q       <= 1'b0;
			end
			if (cmd.meas_fin)
				smooth_meas_q <= sample_q + prod_rnd[DataW-1:0];
			if (cmd.dfin)
				smooth_diff_q <= raw_q + prod_rnd[DiffW-1:0];
			if (cmd.clamp_en) begin
				if (!over)
					err_sum_q <= sum_new_q;
				last_err_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			target_q <= target;
			sample_q <= sample;
		end
		if (cmd.err_en)
			err_q <= e_db;
		if (cmd.sum_en) begin
			sum_new_q <= s_sat;
			raw_q     <= DiffW'(err_q) - DiffW'(last_err_q);
			acc_q     <= AccW'(base_q);
		end
		if (cmd.lo_en)
			lo_q <= prod_q[LoW-1:0];
		if (cmd.term_en)
			term_q <= full_r[AccW-1:0];
		if (cmd.acc_en)
			acc_q <= acc_q + term_q;
		if (cmd.clamp_en)
			out_data_q <= drive_d;
	end

	assign stat.first = first_q;
	assign drive      = out_data_q;

endmodule
`default_nettype wire

/* rtl/pidtr_ctrl.sv */
`default_nettype none
module pidtr_ctrl
	import pidtr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output      logic     s_tready,
	output      logic     m_tvalid,
	input  wire logic     m_tready,
	input  wire dp_stat_t stat,
	output      dp_cmd_t  cmd
);

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_MMUL  = 15'b000000000000010,
		ST_MFIN  = 15'b000000000000100,
		ST_ERR   = 15'b000000000001000,
		ST_SUM   = 15'b000000000010000,
		ST_DMUL  = 15'b000000000100000,
		ST_DFIN  = 15'b000000001000000,
		ST_PMUL  = 15'b000000010000000,
		ST_ILO   = 15'b000000100000000,
		ST_IHI   = 15'b000001000000000,
		ST_DTRM  = 15'b000010000000000,
		ST_TI    = 15'b000100000000000,
		ST_ACCD  = 15'b001000000000000,
		ST_CLAMP = 15'b010000000000000,
		ST_SPARE = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_sel = MUL_P;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MMUL;
				end
			end
			ST_MMUL: begin
				cmd.mul_sel = MUL_MEAS;
				if (stat.first) begin
					cmd.seed = 1'b1;
					state_d  = ST_ERR;
				end else begin
					state_d  = ST_MFIN;
				end
			end
			ST_MFIN: begin
				cmd.meas_fin = 1'b1;
				state_d      = ST_ERR;
			end
			ST_ERR: begin
				cmd.err_en = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_DMUL;
			end
			ST_DMUL: begin
				cmd.mul_sel = MUL_DIFF;
				state_d     = ST_DFIN;
			end
			ST_DFIN: begin
				cmd.dfin = 1'b1;
				state_d  = ST_PMUL;
			end
			ST_PMUL: begin
				cmd.mul_sel = MUL_P;
				state_d     = ST_ILO;
			end
			ST_ILO: begin
				cmd.mul_sel = MUL_ILO;
				cmd.term_en = 1'b1;
				state_d     = ST_IHI;
			end
			ST_IHI: begin
				cmd.mul_sel = MUL_IHI;
				cmd.lo_en   = 1'b1;
				cmd.acc_en  = 1'b1;
				state_d     = ST_DTRM;
			end
			ST_DTRM: begin
				cmd.mul_sel = MUL_D;
				cmd.term_en = 1'b1;
				cmd.term_lo = 1'b1;
				state_d     = ST_TI;
			end
			ST_TI: begin
				cmd.term_en = 1'b1;
				cmd.acc_en  = 1'b1;
				state_d     = ST_ACCD;
			end
			ST_ACCD: begin
				cmd.acc_en = 1'b1;
				state_d    = ST_CLAMP;
			end
			ST_CLAMP: begin
				// hold the finished sum until the output register is free
				if (out_free) begin
					cmd.clamp_en = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clamp_en)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/pid_temperature_regulator.sv */
// PID temperature regulator, signed Q16.16 throughout
// input stream: s_tvalid/s_tready/s_tdata carries one target and one measured
//   sample per word; each word gives exactly one drive word on the m_ stream
// configuration: cfg_we/cfg_index/cfg_data writes one of eight registers per
//   cycle; the user must write only while no word is in flight, the block has no check
// first sample: after reset the measurement filter is seeded instead of computed,
//   so that word skips the MFIN step
// pacing: a new word is accepted only back in idle, once the last is done; the single
//   35x32 multiplier is shared in turn by the filters and the three gain terms
// reset: gains, deadband and baseline clear to zero, the upper clamp goes to
//   the largest positive value, integral and filter state clear, and the next
//   sample seeds the measurement filter
// stall: the result sits in an output register; the next word is accepted and
//   worked on meanwhile, and only its final clamp step waits for the register
`default_nettype none
module pid_temperature_regulator
	import pidtr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output      logic                s_tready,
	input  wire logic [63:0]         s_tdata,   // target [31:0], sample [63:32]
	output      logic                m_tvalid,
	input  wire logic                m_tready,
	output      logic [31:0]         m_tdata,   // drive [31:0]
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [DataW-1:0]    cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pidtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pidtr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.target    (s_tdata[31:0]),
		.sample    (s_tdata[63:32]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.drive     (m_tdata)
	);

endmodule
`default_nettype wire

/* rtl/pidtr_chk.sv */
`default_nettype none
module pidtr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// a result is loaded only on the way back to idle
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("new result without return to idle");

	// no result yet when a new word reaches MFIN or ERR
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> ##1 !m_tvalid)
		else $error("result too early");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result dropped or changed");

endmodule

bind pid_temperature_regulator pidtr_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

/* tb/pid_drive_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module pid_drive_checker
	import pidtr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [DataW-1:0]   cfg_data,
	output int               fail_count,
	output int               pending,
	output int               drives_seen
);
	localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam longint W_HI = 64'sh7FFF_FFFF;
	localparam longint W_LO = -W_HI - 1;

	// register copies
	longint kp, ki, kd, dz, base, ceil_v, wm, wd;
	// loop state
	longint acc, prev_err, meas_f, diff_f;
	bit     seeded;
	logic [31:0] drive_q[$];

	assign pending = drive_q.size();

	function automatic longint rshift16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint gain_term(longint g, longint x);
		longint lo, hi;
		lo = x & 64'hFFFF;
		hi = (x - lo) >>> 16;
		return g * hi + rshift16(g * lo);
	endfunction

	function automatic longint lowpass(longint w, longint old_v, longint new_v);
		return rshift16(w * old_v + (64'sd65536 - w) * new_v);
	endfunction

	function automatic logic [31:0] next_drive(longint tgt, longint smp);
		longint e, mag, old_acc, d;
		if (!seeded) begin
			meas_f = smp;
			seeded = 1;
		end else begin
			meas_f = lowpass(wm, meas_f, smp);
		end
		e = tgt - meas_f;
		if (e > W_HI) e = W_HI;
		if (e < W_LO) e = W_LO;
		mag = e < 0 ? -e : e;
		if (mag < dz) e = 0;
		old_acc = acc;
		acc += e;
		if (acc > SUM_HI) acc = SUM_HI;
		if (acc < SUM_LO) acc = SUM_LO;
		diff_f = lowpass(wd, diff_f, e - prev_err);
		d = base + gain_term(kp, e) + gain_term(ki, acc) + gain_term(kd, diff_f);
		if (d > ceil_v) begin
			d = ceil_v;
			acc = old_acc;
		end
		if (d < base) d = base;
		prev_err = e;
		return d[31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = 0; ki = 0; kd = 0; dz = 0; base = 0; wm = 0; wd = 0;
			ceil_v = W_HI;
			acc = 0; prev_err = 0; meas_f = 0; diff_f = 0; seeded = 0;
			fail_count = 0;
			drives_seen = 0;
			drive_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GAIN_PROP:     kp = cfg_data[30:0];
					REG_GAIN_INT_DT:   ki = cfg_data[30:0];
					REG_GAIN_DER:      kd = cfg_data[30:0];
					REG_DEAD_ZONE:     dz = cfg_data[30:0];
					REG_BASE_DRIVE:    base = longint'($signed(cfg_data));
					REG_MEAS_SMOOTH:   wm = cfg_data[15:0];
					REG_DIFF_SMOOTH:   wd = cfg_data[15:0];
					REG_DRIVE_CEILING: ceil_v = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				drive_q.push_back(next_drive(longint'($signed(s_tdata[31:0])),
					longint'($signed(s_tdata[63:32]))));
			if (m_tvalid && m_tready) begin
				drives_seen++;
				if (drive_q.size() == 0) begin
					$display("%0t: unexpected drive word %h", $time, m_tdata);
					fail_count++;
				end else begin
					if (m_tdata !== drive_q[0]) begin
						$display("%0t: drive mismatch expected %h actual %h",
							$time, drive_q[0], m_tdata);
						fail_count++;
					end
					void'(drive_q.pop_front());
				end
			end
		end
	end
endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import pidtr_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_we;
	logic [63:0] s_tdata;
	logic [31:0] m_tdata;
	logic [CfgIdxW-1:0] cfg_index;
	logic [DataW-1:0] cfg_data;
	int fail_count, pending, drives_seen;
	int samples_sent, idle_cycles;
	bit hold_drive;
	logic [31:0] plant_temp;

	pid_temperature_regulator i_dut (.*);

	pid_drive_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_word(logic [31:0] tgt, logic [31:0] smp, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 11) : 0;
		if ($urandom_range(0, 7) == 0) gap = 0;
		repeat (gap) @(negedge clk);
		s_tvalid <= 1;
		s_tdata <= {smp, tgt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		samples_sent++;
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 32'h0004_0000);
			default: return $urandom & 32'h000F_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] rand_temp();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return 32'(plant_temp + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
		endcase
	endfunction

	task automatic random_settings(bit extreme);
		write_reg(REG_GAIN_PROP, extreme ? 32'h7FFF_FFFF : rand_gain());
		write_reg(REG_GAIN_INT_DT, extreme ? 32'h7FFF_FFFF : rand_gain());
		write_reg(REG_GAIN_DER, extreme ? 32'h7FFF_FFFF : rand_gain());
		write_reg(REG_DEAD_ZONE, extreme ? 32'h7FFF_FFFF
			: ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 32'h0002_0000)));
		write_reg(REG_BASE_DRIVE, extreme ? 32'h8000_0000
			: ($urandom_range(0, 1) ? 0 : $urandom));
		write_reg(REG_MEAS_SMOOTH, extreme ? 32'hFFFF : $urandom_range(0, 16'hFFFF));
		write_reg(REG_DIFF_SMOOTH, extreme ? 32'hFFFF : $urandom_range(0, 16'hFFFF));
		write_reg(REG_DRIVE_CEILING, extreme ? 32'h8000_0000
			: ($urandom_range(0, 2) == 0 ? 32'h7FFF_FFFF : $urandom));
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_drive) begin
				m_tready <= 0;
				repeat (300) @(negedge clk);
				hold_drive = 0;
			end
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
			m_tready <= 0;
			repeat (gap) @(negedge clk);
			m_tready <= 1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
		end
	end

	// watchdog on accepted words
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("timeout waiting for a word");
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_we = 0;
		cfg_index = REG_GAIN_PROP;
		cfg_data = 0;
		samples_sent = 0;
		hold_drive = 0;
		plant_temp = 32'h0014_0000;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings, first sample seeds the filter
		send_word(32'h0019_0000, 32'h0014_0000, 0);
		send_word(32'h7FFF_FFFF, 32'h8000_0000, 0);
		drain();
		write_reg(REG_GAIN_PROP, 32'h0001_0000);
		write_reg(REG_GAIN_INT_DT, 32'h0000_8000);
		write_reg(REG_GAIN_DER, 32'h0000_4000);
		write_reg(REG_DEAD_ZONE, 32'h0000_8000);
		write_reg(REG_BASE_DRIVE, 32'h0000_1000);
		write_reg(REG_MEAS_SMOOTH, 32'h0000_8000);
		write_reg(REG_DIFF_SMOOTH, 32'h0000_C000);
		write_reg(REG_DRIVE_CEILING, 32'h0064_0000);
		// error extremes, clamp hits
		send_word(32'h0014_4000, 32'h0014_0000, 0);
		send_word(32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_word(32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_word(32'h0000_0000, 32'h0000_0000, 0);
		drain();
		// all extremes, crossed clamps
		random_settings(1);
		write_reg(REG_DRIVE_CEILING, 32'h7FFF_FFFF);
		for (int i = 0; i < 8; i++)
			send_word(32'h7FFF_FFFF, 32'h8000_0000, 0);
		drain();
		write_reg(REG_DEAD_ZONE, 0);
		write_reg(REG_BASE_DRIVE, 32'h7FFF_FFFF);
		write_reg(REG_DRIVE_CEILING, 32'h8000_0000);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			random_settings(phase == 5);
			if (phase == 3) hold_drive = 1;
			for (int i = 0; i < 150; i++) begin
				plant_temp = 32'(plant_temp + $urandom_range(0, 32'h2_0000) - 32'h1_0000);
				send_word(rand_temp(), rand_temp(), 1);
				if (i == 75 && phase == 7) drain();
			end
			drain();
		end
		repeat (30) @(negedge clk);
		$display("sent %0d samples over 12 random settings plus directed extremes", samples_sent);
		$display("checked %0d drive words", drives_seen);
		if (fail_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
